/* rtl/bfa_pkg.sv */
// Package for the bitmap frame allocator: field widths, status and operation
// codes, parameter defaults and the probe flag struct. No dependencies.
package bfa_pkg;

  // Parameter defaults
  localparam int BFA_MAX_FRAMES = 1024;
  localparam int BFA_WORD_BITS  = 32;

  // Fixed field widths
  localparam int CFG_W    = 11;
  localparam int FRAME_W  = 10;
  localparam int STATUS_W = 3;

  // Reset value of the frame count register
  localparam logic [CFG_W-1:0] FRAME_COUNT_RST = 11'd1024;

  // Operation codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_ALLOCATED    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_MAPPED       = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FREED        = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ALREADY_FREE = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NO_MEMORY    = 3'd4;

  // What the probe unit reports on one bitmap word
  typedef struct packed {
    logic hit;   // word holds the wanted bit
    logic full;  // every bit of the word is set
  } bfa_probe_t;

endpackage

/* rtl/bitmap_frame_allocator.sv */
// Bitmap frame allocator, top level. Uses bfa_pkg and bfa_probe.
// Mapped or unmapped-free items skip the bitmap and go straight to the result;
// alloc and free walk the bitmap one word a cycle through the shared probe,
// one item at a time. Throughput is set by that walk and by out_stall.
// Reset (rst_n low, synchronous) starts a clearing pass that zeroes the
// bitmap; in_stall stays high until it ends.
module bitmap_frame_allocator import bfa_pkg::*; #(
  parameter int MAX_FRAMES = BFA_MAX_FRAMES,
  parameter int WORD_BITS  = BFA_WORD_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  // configuration write channel
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CFG_W-1:0]    cfg_frame_count,
  // request channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_operation,
  input  logic [FRAME_W-1:0]  in_entry_frame,
  input  logic                in_want_present,
  input  logic                in_want_writable,
  input  logic                in_want_user,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] out_status,
  output logic [FRAME_W-1:0]  out_new_frame,
  output logic                out_entry_present,
  output logic                out_entry_writable,
  output logic                out_entry_user
);

  localparam int WORD_COUNT = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int AW         = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int BW         = $clog2(WORD_BITS);
  localparam int SPAN       = WORD_COUNT * WORD_BITS;
  localparam int FW0        = $clog2(SPAN) + 1;
  // frame arithmetic width: wide enough for the whole bitmap and the register
  localparam int FW         = (FW0 > CFG_W) ? FW0 : CFG_W;

  localparam logic [AW-1:0] LAST_WORD = AW'(WORD_COUNT - 1);
  localparam logic [FW-1:0] MAX_EXT   = FW'(MAX_FRAMES);
  localparam logic [FW-1:0] WORD_STEP = FW'(WORD_BITS);

  // sequencer codes
  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_WALK   = 3'd2;
  localparam logic [2:0] S_COMMIT = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0]           state_r, state_nxt;
  logic [AW-1:0]        wid_r, wid_nxt;        // word under probe / clear pointer
  logic [FW-1:0]        base_r, base_nxt;      // first frame of that word
  logic [CFG_W-1:0]     fcount_r;
  logic                 op_r, op_nxt;
  logic [FRAME_W-1:0]   entry_r, entry_nxt;
  logic [2:0]           want_r, want_nxt;      // present, writable, user
  logic [WORD_BITS-1:0] word_r, word_nxt;
  logic [BW-1:0]        bit_r, bit_nxt;

  // result held between the sequencer and the output register
  logic [STATUS_W-1:0]  res_status_r, res_status_nxt;
  logic [FRAME_W-1:0]   res_frame_r, res_frame_nxt;
  logic [2:0]           res_flags_r, res_flags_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]  out_status_r;
  logic [FRAME_W-1:0]   out_frame_r;
  logic [2:0]           out_flags_r;

  // bitmap memory
  logic [WORD_BITS-1:0] bitmap_mem [WORD_COUNT];
  logic [WORD_BITS-1:0] rdata_r;
  logic                 mem_re, mem_we;
  logic [AW-1:0]        mem_ra;
  logic [WORD_BITS-1:0] mem_wd;

  logic                 in_acc;
  logic                 out_load;
  logic [FW-1:0]        entry_ext;
  logic [FW-1:0]        alloc_frame;
  logic                 alloc_ok;
  logic [WORD_BITS-1:0] bit_mask;
  bfa_probe_t           probe;
  logic [BW-1:0]        probe_idx;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;

  assign entry_ext = FW'(entry_r);

  // shared probe: sees the word read last cycle and the base of that word
  bfa_probe #(
    .WORD_BITS (WORD_BITS),
    .FW        (FW)
  ) u_probe (
    .word    (rdata_r),
    .base    (base_r),
    .entry   (entry_ext),
    .op_free (op_r),
    .probe   (probe),
    .bit_idx (probe_idx)
  );

  // commit arithmetic: frame number of the chosen bit against the limit
  assign bit_mask    = WORD_BITS'(1) << bit_r;
  assign alloc_frame = base_r + FW'(bit_r);
  assign alloc_ok    = (alloc_frame < FW'(fcount_r)) && (alloc_frame < MAX_EXT);

  // output register frees up when empty or taken this cycle
  assign out_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt      = state_r;
    wid_nxt        = wid_r;
    base_nxt       = base_r;
    op_nxt         = op_r;
    entry_nxt      = entry_r;
    want_nxt       = want_r;
    word_nxt       = word_r;
    bit_nxt        = bit_r;
    res_status_nxt = res_status_r;
    res_frame_nxt  = res_frame_r;
    res_flags_nxt  = res_flags_r;
    mem_re         = 1'b0;
    mem_ra         = AW'(wid_r + 1'b1);
    mem_we         = 1'b0;
    mem_wd         = '0;

    case (state_r)
      S_CLEAR: begin
        // zero one word a cycle
        mem_we  = 1'b1;
        mem_wd  = '0;
        wid_nxt = AW'(wid_r + 1'b1);
        if (wid_r == LAST_WORD) begin
          wid_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          op_nxt        = in_operation;
          entry_nxt     = in_entry_frame;
          want_nxt      = {in_want_present, in_want_writable, in_want_user};
          wid_nxt       = '0;
          base_nxt      = '0;
          res_frame_nxt = '0;
          res_flags_nxt = '0;
          mem_ra        = '0;
          if (in_operation == OP_ALLOC) begin
            if (in_entry_frame != '0) begin
              // entry already holds a frame: hand it back untouched
              res_status_nxt = ST_MAPPED;
              res_frame_nxt  = in_entry_frame;
              state_nxt      = S_DONE;
            end else begin
              mem_re    = 1'b1;
              state_nxt = S_WALK;
            end
          end else begin
            if (in_entry_frame == '0) begin
              res_status_nxt = ST_ALREADY_FREE;
              state_nxt      = S_DONE;
            end else if (FW'(in_entry_frame) >= MAX_EXT) begin
              // frame beyond the bitmap: nothing to clear
              res_status_nxt = ST_FREED;
              state_nxt      = S_DONE;
            end else begin
              mem_re    = 1'b1;
              state_nxt = S_WALK;
            end
          end
        end
      end
      S_WALK: begin
        if (probe.hit) begin
          word_nxt  = rdata_r;
          bit_nxt   = probe_idx;
          state_nxt = S_COMMIT;
        end else if (wid_r == LAST_WORD) begin
          // every word full: out of memory
          res_status_nxt = ST_NO_MEMORY;
          res_frame_nxt  = '0;
          state_nxt      = S_DONE;
        end else begin
          // advance to the next word, fetching it now
          mem_re   = 1'b1;
          wid_nxt  = AW'(wid_r + 1'b1);
          base_nxt = base_r + WORD_STEP;
        end
      end
      S_COMMIT: begin
        if (op_r == OP_FREE) begin
          mem_we         = 1'b1;
          mem_wd         = word_r & ~bit_mask;
          res_status_nxt = ST_FREED;
        end else if (alloc_ok) begin
          mem_we         = 1'b1;
          mem_wd         = word_r | bit_mask;
          res_status_nxt = ST_ALLOCATED;
          res_frame_nxt  = alloc_frame[FRAME_W-1:0];
          res_flags_nxt  = want_r;
        end else begin
          // lowest free bit lies at or past the limit
          res_status_nxt = ST_NO_MEMORY;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      wid_r       <= '0;
      fcount_r    <= FRAME_COUNT_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wid_r       <= wid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        fcount_r <= cfg_frame_count;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    base_r       <= base_nxt;
    op_r         <= op_nxt;
    entry_r      <= entry_nxt;
    want_r       <= want_nxt;
    word_r       <= word_nxt;
    bit_r        <= bit_nxt;
    res_status_r <= res_status_nxt;
    res_frame_r  <= res_frame_nxt;
    res_flags_r  <= res_flags_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_frame_r  <= res_frame_r;
      out_flags_r  <= res_flags_r;
    end
  end

  // bitmap: one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      bitmap_mem[wid_r] <= mem_wd;
    end
    if (mem_re) begin
      rdata_r <= bitmap_mem[mem_ra];
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_new_frame      = out_frame_r;
  assign out_entry_present  = out_flags_r[2];
  assign out_entry_writable = out_flags_r[1];
  assign out_entry_user     = out_flags_r[0];

endmodule

/* rtl/bfa_probe.sv */
// Shared word probe: lowest-clear-bit search for allocation, word-offset
// compare for release. Depends on bfa_pkg.
module bfa_probe import bfa_pkg::*; #(
  parameter int WORD_BITS = BFA_WORD_BITS,
  parameter int FW        = 12
) (
  input  logic [WORD_BITS-1:0]         word,
  input  logic [FW-1:0]                base,
  input  logic [FW-1:0]                entry,
  input  logic                         op_free,
  output bfa_probe_t                   probe,
  output logic [$clog2(WORD_BITS)-1:0] bit_idx
);

  localparam int BW = $clog2(WORD_BITS);

  logic [BW-1:0] zero_idx;
  logic [FW-1:0] offset;
  logic          full;

  // lowest clear bit wins
  always_comb begin
    zero_idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!word[i]) begin
        zero_idx = BW'(i);
      end
    end
  end

  assign full   = &word;
  assign offset = entry - base;

  always_comb begin
    probe.full = full;
    if (op_free == OP_FREE) begin
      probe.hit = (offset < FW'(WORD_BITS));
      bit_idx   = offset[BW-1:0];
    end else begin
      probe.hit = !full;
      bit_idx   = zero_idx;
    end
  end

endmodule

/* rtl/bfa_checker.sv */
// Port-level checks for the bitmap frame allocator, bound to the top level.
// Depends on bfa_pkg and bitmap_frame_allocator.
module bfa_checker import bfa_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                cfg_valid,
  input logic                cfg_ready,
  input logic [CFG_W-1:0]    cfg_frame_count,
  input logic                in_valid,
  input logic                in_stall,
  input logic                in_operation,
  input logic [FRAME_W-1:0]  in_entry_frame,
  input logic                in_want_present,
  input logic                in_want_writable,
  input logic                in_want_user,
  input logic                out_valid,
  input logic                out_stall,
  input logic [STATUS_W-1:0] out_status,
  input logic [FRAME_W-1:0]  out_new_frame,
  input logic                out_entry_present,
  input logic                out_entry_writable,
  input logic                out_entry_user
);

  // a held item keeps its status, frame and present flag
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
      $stable(out_new_frame) && $stable(out_entry_present))
    else $error("result item changed while stalled");

  // after reset the clearing pass blocks requests and no result is shown
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> in_stall && !out_valid)
    else $error("block not clearing after reset");

  // flags only accompany a successful allocation
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_ALLOCATED |->
      !out_entry_present && !out_entry_writable && !out_entry_user)
    else $error("entry flags set without allocation");

  // failed or freeing outcomes carry no frame
  a_no_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_NO_MEMORY || out_status == ST_FREED ||
      out_status == ST_ALREADY_FREE) |-> out_new_frame == '0)
    else $error("frame reported with a non-allocating status");

  // an already-mapped result always names a real frame
  a_mapped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_MAPPED |-> out_new_frame != '0)
    else $error("mapped status with frame zero");

endmodule

bind bitmap_frame_allocator bfa_checker u_bfa_checker (.*);

/* verif/testbench.sv */
// Self-checking testbench for bitmap_frame_allocator: drives alloc/free items,
// predicts each page entry with its own bitmap copy and checks every result.
// Depends on bfa_pkg and the allocator RTL only.
`timescale 1ns / 1ps

module testbench;
  import bfa_pkg::*;

  localparam int HOLD_CYCLES = 400;     // long receiver hold-off
  localparam int TAIL_CYCLES = 60;      // beyond the longest bitmap walk
  localparam int IDLE_PCT    = 18;

  // One request item as it crosses the input channel
  typedef struct packed {
    logic               operation;
    logic [FRAME_W-1:0] entry_frame;
    logic               want_present;
    logic               want_writable;
    logic               want_user;
  } frame_req_t;

  // One resulting page entry
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [FRAME_W-1:0]  frame;
    logic                present;
    logic                writable;
    logic                user;
  } page_entry_t;

  // Keeps its own copy of the used-frame bitmap and the frame count, works out
  // the page entry for each accepted item and holds those entries in order.
  class alloc_scoreboard;
    logic [BFA_MAX_FRAMES-1:0] used_frames;
    logic [CFG_W-1:0]          frame_count;
    page_entry_t               pending_entries[$];
    int unsigned               mismatches;

    function new();
      used_frames = '0;
      frame_count = FRAME_COUNT_RST;
      mismatches  = 0;
    endfunction

    // First fit below min(frame_count, MAX_FRAMES); frees go by frame number.
    function page_entry_t predict_entry(frame_req_t req);
      page_entry_t res;
      int          limit;
      int          f;
      bit          found;
      res   = '0;
      found = 1'b0;
      limit = (frame_count < BFA_MAX_FRAMES) ? int'(frame_count) : BFA_MAX_FRAMES;
      if (req.operation == OP_ALLOC) begin
        if (req.entry_frame != '0) begin
          res.status = ST_MAPPED;
          res.frame  = req.entry_frame;
        end else begin
          res.status = ST_NO_MEMORY;
          for (f = 0; f < limit; f++) begin
            if (!found && !used_frames[f]) begin
              found          = 1'b1;
              used_frames[f] = 1'b1;
              res.status     = ST_ALLOCATED;
              res.frame      = FRAME_W'(f);
              res.present    = req.want_present;
              res.writable   = req.want_writable;
              res.user       = req.want_user;
            end
          end
        end
      end else if (req.entry_frame == '0) begin
        res.status = ST_ALREADY_FREE;
      end else begin
        used_frames[req.entry_frame] = 1'b0;
        res.status = ST_FREED;
      end
      return res;
    endfunction

    function void note_request(frame_req_t req);
      pending_entries.push_back(predict_entry(req));
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(page_entry_t got);
      page_entry_t want;
      if (pending_entries.size() == 0) begin
        $error("result with none pending: status %0d frame %0d", got.status, got.frame);
        mismatches++;
        return;
      end
      want = pending_entries.pop_front();
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("new_frame", 32'(want.frame), 32'(got.frame));
      compare_field("entry_present", 32'(want.present), 32'(got.present));
      compare_field("entry_writable", 32'(want.writable), 32'(got.writable));
      compare_field("entry_user", 32'(want.user), 32'(got.user));
    endfunction

    // A used frame other than zero, starting the search at a random point
    function logic [FRAME_W-1:0] pick_used_frame();
      logic [FRAME_W-1:0] pick;
      int                 start;
      int                 k;
      int                 f;
      pick  = '0;
      start = int'($urandom_range(1, BFA_MAX_FRAMES - 1));
      for (k = 0; k < BFA_MAX_FRAMES; k++) begin
        f = (start + k) % BFA_MAX_FRAMES;
        if (pick == '0 && f != 0 && used_frames[f]) pick = FRAME_W'(f);
      end
      return pick;
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CFG_W-1:0]    cfg_frame_count = FRAME_COUNT_RST;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                in_operation = OP_ALLOC;
  logic [FRAME_W-1:0]  in_entry_frame = '0;
  logic                in_want_present = 1'b0;
  logic                in_want_writable = 1'b0;
  logic                in_want_user = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [FRAME_W-1:0]  out_new_frame;
  logic                out_entry_present;
  logic                out_entry_writable;
  logic                out_entry_user;

  alloc_scoreboard sb = new();

  // Both sides stop idling while quiet is set; a flip of hold_toggle makes the
  // receiver hold off for HOLD_CYCLES, counted by the receiver itself.
  bit quiet = 1'b0;
  bit hold_toggle = 1'b0;

  bitmap_frame_allocator u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_frame_count    (cfg_frame_count),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_operation       (in_operation),
    .in_entry_frame     (in_entry_frame),
    .in_want_present    (in_want_present),
    .in_want_writable   (in_want_writable),
    .in_want_user       (in_want_user),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_new_frame      (out_new_frame),
    .out_entry_present  (out_entry_present),
    .out_entry_writable (out_entry_writable),
    .out_entry_user     (out_entry_user)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic frame_req_t make_req(logic op, logic [FRAME_W-1:0] entry,
                                          logic p, logic w, logic u);
    frame_req_t req;
    req.operation     = op;
    req.entry_frame   = entry;
    req.want_present  = p;
    req.want_writable = w;
    req.want_user     = u;
    return req;
  endfunction

  // Mostly unmapped allocations and frees of live frames; the rest is noise:
  // allocations onto mapped entries, frees of random or unmapped entries.
  function automatic frame_req_t random_request(int alloc_pct, int mapped_pct);
    frame_req_t req;
    int         roll;
    req = make_req(OP_ALLOC, '0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
    roll = $urandom_range(0, 99);
    if (roll >= alloc_pct && roll < alloc_pct + mapped_pct) begin
      req.entry_frame = FRAME_W'($urandom_range(1, BFA_MAX_FRAMES - 1));
    end else if (roll >= alloc_pct + mapped_pct) begin
      req.operation = OP_FREE;
      roll = $urandom_range(0, 99);
      if (roll < 75) req.entry_frame = sb.pick_used_frame();
      else if (roll < 90) req.entry_frame = FRAME_W'($urandom_range(0, BFA_MAX_FRAMES - 1));
    end
    return req;
  endfunction

  // Offer one item after a random idle gap, hold it until accepted, then
  // note it. Valid stays high between back-to-back items.
  task automatic send_request(input frame_req_t req);
    int gap;
    gap = 0;
    if (!quiet) begin
      while (gap < 12 && $urandom_range(0, 99) < IDLE_PCT) gap++;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_operation     <= req.operation;
    in_entry_frame   <= req.entry_frame;
    in_want_present  <= req.want_present;
    in_want_writable <= req.want_writable;
    in_want_user     <= req.want_user;
    do @(posedge clk); while (in_stall);
    sb.note_request(req);
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (sb.pending_entries.size() != 0) @(posedge clk);
  endtask

  // Write the frame count only once every expected result is back: every item
  // gives exactly one result, so the block is idle by then.
  task automatic write_frame_count(input logic [CFG_W-1:0] value);
    wait_results_drained();
    cfg_valid       <= 1'b1;
    cfg_frame_count <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid      <= 1'b0;
    sb.frame_count = value;
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] count, input int n_items,
                           input int alloc_pct, input int mapped_pct,
                           input bit with_pressure);
    int i;
    write_frame_count(count);
    for (i = 0; i < n_items; i++) begin
      if (with_pressure) begin
        // no idling on either side for a stretch
        quiet = (i >= 200 && i < 450);
        // hold off the receiver while items keep coming, so the input stalls
        if (i == 600) hold_toggle = ~hold_toggle;
        // pause the sender until every result is back
        if (i == 800) wait_results_drained();
      end
      send_request(random_request(alloc_pct, mapped_pct));
    end
    quiet = 1'b0;
  endtask

  initial begin : stimulus
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset count of 1024 frames
    send_request(make_req(OP_ALLOC, 10'd0, 1'b1, 1'b1, 1'b1));   // frame zero handed out
    send_request(make_req(OP_ALLOC, 10'd0, 1'b0, 1'b0, 1'b0));
    send_request(make_req(OP_ALLOC, 10'd0, 1'b1, 1'b0, 1'b1));
    send_request(make_req(OP_ALLOC, 10'd0, 1'b0, 1'b1, 1'b0));
    send_request(make_req(OP_ALLOC, 10'd1023, 1'b1, 1'b1, 1'b1)); // already mapped
    send_request(make_req(OP_ALLOC, 10'd1, 1'b0, 1'b0, 1'b0));
    send_request(make_req(OP_FREE, 10'd0, 1'b1, 1'b1, 1'b1));     // unmapped entry
    send_request(make_req(OP_FREE, 10'd2, 1'b0, 1'b0, 1'b0));
    send_request(make_req(OP_FREE, 10'd2, 1'b0, 1'b0, 1'b0));     // frame not in use
    send_request(make_req(OP_FREE, 10'd1023, 1'b1, 1'b1, 1'b1));
    send_request(make_req(OP_ALLOC, 10'd0, 1'b1, 1'b1, 1'b0));   // refills the hole
    send_request(make_req(OP_FREE, 10'd512, 1'b0, 1'b1, 1'b0));

    // A count of zero leaves nothing to allocate
    write_frame_count(11'd0);
    send_request(make_req(OP_ALLOC, 10'd0, 1'b1, 1'b1, 1'b1));
    send_request(make_req(OP_FREE, 10'd1, 1'b0, 1'b0, 1'b0));
    send_request(make_req(OP_ALLOC, 10'd0, 1'b1, 1'b0, 1'b0));

    // A count above the bitmap size is clipped to it
    write_frame_count(11'd2047);
    send_request(make_req(OP_ALLOC, 10'd0, 1'b0, 1'b0, 1'b1));
    send_request(make_req(OP_ALLOC, 10'd0, 1'b1, 1'b1, 1'b1));

    // One frame, already taken
    write_frame_count(11'd1);
    send_request(make_req(OP_ALLOC, 10'd0, 1'b1, 1'b1, 1'b1));

    // Five frames, all taken, then one given back
    write_frame_count(11'd5);
    send_request(make_req(OP_ALLOC, 10'd0, 1'b1, 1'b1, 1'b1));
    send_request(make_req(OP_FREE, 10'd3, 1'b1, 1'b1, 1'b1));
    send_request(make_req(OP_ALLOC, 10'd0, 1'b0, 1'b1, 1'b1));

    // Random part: small pools run dry often; the big phase caps the pool at
    // 1000 frames, part way into the last bitmap word, below the full bitmap.
    run_phase(11'd40, 120, 55, 10, 1'b0);
    run_phase(11'd5, 40, 50, 10, 1'b0);
    run_phase(11'd1000, 1050, 95, 2, 1'b1);
    run_phase(11'd2047, 100, 50, 15, 1'b0);
    run_phase(11'd1024, 60, 40, 20, 1'b0);

    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Accept results and drive the receiver's stall
  initial begin : result_monitor
    page_entry_t got;
    bit          seen_toggle;
    int          hold_left;
    seen_toggle = 1'b0;
    hold_left   = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got.status   = out_status;
        got.frame    = out_new_frame;
        got.present  = out_entry_present;
        got.writable = out_entry_writable;
        got.user     = out_entry_user;
        sb.check_result(got);
      end
      if (hold_toggle != seen_toggle) begin
        seen_toggle = hold_toggle;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (quiet) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  // Give up well past the slowest correct run
  initial begin : watchdog
    #1500000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
